@@ hw/rtl/bfe_pkg.sv @@
// ============================================================================
// bfe_pkg
// Shared widths, types, register indexes and reset values for the
// bitcrushed feedback echo.
// ============================================================================
`timescale 1ns / 1ps

package bfe_pkg;

   localparam int STORE_DEPTH_DEF = 131072;
   localparam int LEVEL_BITS_DEF  = 8;

   localparam int AUDIO_W     = 16;
   localparam int DELAY_W     = 17;
   localparam int HOLD_W      = 5;
   localparam int HOLD_CNT_W  = 4;
   localparam int HOLD_MAX    = 16;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;
   localparam int MIX_W       = 36;
   localparam int Q_FRAC      = 15;

   typedef logic signed [AUDIO_W-1:0] sample_type;
   typedef logic [CSR_INDEX_W-1:0]    csr_index_type;
   typedef logic [CSR_DATA_W-1:0]     csr_data_type;

   localparam csr_index_type REG_DELAY_LENGTH  = 3'd0;
   localparam csr_index_type REG_HOLD_FACTOR   = 3'd1;
   localparam csr_index_type REG_FEEDBACK_GAIN = 3'd2;
   localparam csr_index_type REG_DRY_GAIN      = 3'd3;
   localparam csr_index_type REG_WET_GAIN      = 3'd4;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd44100;
   localparam logic [HOLD_W-1:0]  HOLD_RESET  = 5'd2;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd22938;

   // clamp a wide signed value to the 16-bit sample range
   function automatic sample_type sat_sample(input logic signed [MIX_W-1:0] v);
      logic signed [MIX_W-1:0] hi;
      logic signed [MIX_W-1:0] lo;
      hi = MIX_W'(32767);
      lo = -MIX_W'(32768);
      if (v > hi) begin
         sat_sample = 16'sh7FFF;
      end else if (v < lo) begin
         sat_sample = 16'sh8000;
      end else begin
         sat_sample = v[AUDIO_W-1:0];
      end
   endfunction

endpackage

@@ hw/rtl/bfe_req_if.sv @@
// ============================================================================
// bfe_req_if
// Input sample channel: valid/ready handshake with one audio sample.
// ============================================================================
`timescale 1ns / 1ps

interface bfe_req_if;
   import bfe_pkg::*;

   logic       valid;
   logic       ready;
   sample_type audio_in;

   modport source (output valid, output audio_in, input ready);
   modport sink   (input valid, input audio_in, output ready);
endinterface

@@ hw/rtl/bfe_rsp_if.sv @@
// ============================================================================
// bfe_rsp_if
// Output sample channel: valid/ready handshake with one mixed sample.
// ============================================================================
`timescale 1ns / 1ps

interface bfe_rsp_if;
   import bfe_pkg::*;

   logic       valid;
   logic       ready;
   sample_type audio_out;

   modport source (output valid, output audio_out, input ready);
   modport sink   (input valid, input audio_out, output ready);
endinterface

@@ hw/rtl/bfe_ram.sv @@
// ============================================================================
// bfe_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ============================================================================
`timescale 1ns / 1ps

module bfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ hw/rtl/bitcrushed_feedback_echo_core.sv @@
// ============================================================================
// bitcrushed_feedback_echo_core
// One-channel bitcrushed echo: quantize, sample-hold, feedback delay line, mix.
// ============================================================================
`timescale 1ns / 1ps

// Takes one signed Q1.15 sample per transaction and returns one mixed sample.
// A new transaction is taken every cycle while the pipeline advances. The
// result is offered once it has passed the feedback and dry multiply, the
// store write and wet multiply, and the mix into the output register. The
// whole pipeline advances in lockstep and only stops when a finished result
// waits behind an output register that the sink has not emptied, so
// throughput is one sample per clock whenever the sink keeps up.
// The echo line is one RAM of STORE_DEPTH words with one read and one write
// port; a word that is still on its way to the RAM (its producer is still in
// stage 1 or stage 2) is forwarded from the pipeline instead.
// The line starts out reading as silence: a write pointer plus a wrapped flag
// mark which words have been written, so no clearing pass runs after reset
// and the block is ready as soon as reset is released. Configuration
// writes go through csr_we/csr_index/csr_wdata and must only happen while no
// transaction is in flight.

module bitcrushed_feedback_echo_core #(
   parameter int STORE_DEPTH = bfe_pkg::STORE_DEPTH_DEF,
   parameter int LEVEL_BITS  = bfe_pkg::LEVEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   bfe_req_if.sink               req_chan,
   bfe_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  bfe_pkg::csr_index_type csr_index,
   input  bfe_pkg::csr_data_type  csr_wdata
);
   import bfe_pkg::*;

   localparam int AW  = $clog2(STORE_DEPTH);
   localparam int CW  = $clog2(STORE_DEPTH + 1);
   localparam int EW  = (CW > DELAY_W) ? CW : DELAY_W;
   localparam int QSH = AUDIO_W - 1 - LEVEL_BITS;
   localparam logic [AUDIO_W:0] QMASK = {(AUDIO_W+1){1'b1}} << QSH;
   localparam int EP_W = 2 * AUDIO_W + 1;       // feedback / dry product
   localparam int E_W  = EP_W - Q_FRAC;         // feedback term after floor
   localparam int WP_W = GAIN_W + E_W + 1;      // wet product

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DELAY_W-1:0] delay_ff;
   logic [HOLD_W-1:0]  hold_ff;
   logic [GAIN_W-1:0]  fb_gain_ff, dry_gain_ff, wet_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= DELAY_RESET;
         hold_ff     <= HOLD_RESET;
         fb_gain_ff  <= GAIN_RESET;
         dry_gain_ff <= GAIN_RESET;
         wet_gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_DELAY_LENGTH:  delay_ff    <= csr_wdata[DELAY_W-1:0];
            REG_HOLD_FACTOR:   hold_ff     <= csr_wdata[HOLD_W-1:0];
            REG_FEEDBACK_GAIN: fb_gain_ff  <= csr_wdata[GAIN_W-1:0];
            REG_DRY_GAIN:      dry_gain_ff <= csr_wdata[GAIN_W-1:0];
            REG_WET_GAIN:      wet_gain_ff <= csr_wdata[GAIN_W-1:0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: the pipeline moves unless the output register is stuck
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff;
   logic out_valid_ff;
   logic adv, accept;

   assign adv            = !v3_ff || !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign accept         = req_chan.valid && adv;

   // ---------------------------------------------------------------------
   // Stage 0: quantize, hold, read address
   // ---------------------------------------------------------------------
   sample_type                x0;
   logic signed [AUDIO_W:0]   x0_ext;
   logic [AUDIO_W:0]          mag0, magq0, q0_ext;
   sample_type                q0, held0;
   logic [HOLD_W-1:0]         hf_eff, hc_next;
   logic [HOLD_CNT_W-1:0]     hc_ff, hc_in;
   sample_type                held_ff, held_in;

   assign x0     = req_chan.audio_in;
   assign x0_ext = (AUDIO_W+1)'(x0);
   assign mag0   = x0[AUDIO_W-1] ? (AUDIO_W+1)'(-x0_ext) : (AUDIO_W+1)'(x0_ext);
   assign magq0  = mag0 & QMASK;
   assign q0_ext = x0[AUDIO_W-1] ? ((AUDIO_W+1)'(0) - magq0) : magq0;
   assign q0     = q0_ext[AUDIO_W-1:0];

   always_comb begin
      if (hold_ff == '0) begin
         hf_eff = HOLD_W'(1);
      end else if (hold_ff > HOLD_W'(HOLD_MAX)) begin
         hf_eff = HOLD_W'(HOLD_MAX);
      end else begin
         hf_eff = hold_ff;
      end
   end

   assign hc_next = HOLD_W'(hc_ff) + HOLD_W'(1);
   assign hc_in   = (hc_next >= hf_eff) ? '0 : hc_next[HOLD_CNT_W-1:0];
   assign held0   = (hc_ff == '0) ? q0 : held_ff;
   assign held_in = held0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff   <= '0;
         held_ff <= '0;
      end else if (accept) begin
         hc_ff   <= hc_in;
         held_ff <= held_in;
      end
   end

   // write pointer and "line has wrapped" flag track which words are written
   logic [AW-1:0] wi_ff, wi_in;
   logic          wrap_ff, wrap_in;
   logic          wi_last;

   assign wi_last = (wi_ff == AW'(STORE_DEPTH - 1));
   assign wi_in   = wi_last ? '0 : wi_ff + AW'(1);
   assign wrap_in = wrap_ff || wi_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff   <= '0;
         wrap_ff <= 1'b0;
      end else if (accept) begin
         wi_ff   <= wi_in;
         wrap_ff <= wrap_in;
      end
   end

   logic [EW-1:0] dly_ext, dly_clamp;
   logic [CW-1:0] dly_eff, wi_wide, rd_wide;
   logic [AW-1:0] rd0;
   logic          nz0, m1_0, m2_0;

   assign dly_ext = EW'(delay_ff);
   always_comb begin
      if (dly_ext == '0) begin
         dly_clamp = EW'(1);
      end else if (dly_ext > EW'(STORE_DEPTH)) begin
         dly_clamp = EW'(STORE_DEPTH);
      end else begin
         dly_clamp = dly_ext;
      end
   end
   assign dly_eff = dly_clamp[CW-1:0];
   assign wi_wide = CW'(wi_ff);
   assign rd_wide = (wi_wide >= dly_eff) ? (wi_wide - dly_eff)
                                         : (wi_wide + CW'(STORE_DEPTH) - dly_eff);
   assign rd0     = rd_wide[AW-1:0];

   // never-written words read as zero
   assign nz0  = wrap_ff || (rd0 < wi_ff);

   // words still in the pipeline
   logic [AW-1:0] wi1_ff, wi2_ff;
   assign m1_0 = v1_ff && (rd0 == wi1_ff);
   assign m2_0 = v2_ff && (rd0 == wi2_ff);

   // ---------------------------------------------------------------------
   // Stage 1: select delayed sample, feedback and dry products
   // ---------------------------------------------------------------------
   sample_type ram_rdata;
   sample_type word2;
   sample_type x1_ff, held1_ff, fdat1_ff;
   logic       nz1_ff, f1_ff, f2_ff;
   sample_type delayed1;

   always_ff @(posedge clock) begin
      if (accept) begin
         x1_ff    <= x0;
         held1_ff <= held0;
         wi1_ff   <= wi_ff;
         nz1_ff   <= nz0;
         f1_ff    <= m1_0;
         f2_ff    <= m2_0;
         fdat1_ff <= word2;      // word being written this same cycle
      end
   end

   always_comb begin
      if (f1_ff) begin
         delayed1 = word2;       // producer sits one stage ahead
      end else if (f2_ff) begin
         delayed1 = fdat1_ff;
      end else if (nz1_ff) begin
         delayed1 = ram_rdata;
      end else begin
         delayed1 = '0;
      end
   end

   logic signed [EP_W-1:0] fbp1, dp1;
   assign fbp1 = $signed({{(EP_W-GAIN_W){1'b0}}, fb_gain_ff})
               * $signed({{(EP_W-AUDIO_W){delayed1[AUDIO_W-1]}}, delayed1});
   assign dp1  = $signed({{(EP_W-GAIN_W){1'b0}}, dry_gain_ff})
               * $signed({{(EP_W-AUDIO_W){x1_ff[AUDIO_W-1]}}, x1_ff});

   // ---------------------------------------------------------------------
   // Stage 2: store write-back, wet product
   // ---------------------------------------------------------------------
   logic signed [E_W-1:0]  e2_ff;
   logic signed [EP_W-1:0] dp2_ff;
   sample_type             held2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e2_ff    <= fbp1[EP_W-1:Q_FRAC];   // floor of /2^15
         dp2_ff   <= dp1;
         held2_ff <= held1_ff;
         wi2_ff   <= wi1_ff;
      end
   end

   assign word2 = sat_sample(MIX_W'(held2_ff) + MIX_W'(e2_ff));

   logic signed [WP_W-1:0] wp2;
   assign wp2 = $signed({{(WP_W-GAIN_W){1'b0}}, wet_gain_ff})
              * $signed({{(WP_W-E_W){e2_ff[E_W-1]}}, e2_ff});

   bfe_ram #(
      .WIDTH (AUDIO_W),
      .DEPTH (STORE_DEPTH)
   ) u_echo_ram (
      .clock (clock),
      .we    (v2_ff && adv),
      .waddr (wi2_ff),
      .wdata (word2),
      .re    (accept),
      .raddr (rd0),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // Stage 3: mix, floor, saturate into the output register
   // ---------------------------------------------------------------------
   logic signed [WP_W-1:0]  wp3_ff;
   logic signed [EP_W-1:0]  dp3_ff;
   logic signed [MIX_W-1:0] mix3;
   sample_type              out_ff, out_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         wp3_ff <= wp2;
         dp3_ff <= dp2_ff;
      end
   end

   assign mix3   = MIX_W'(dp3_ff) + MIX_W'(wp3_ff);
   assign out_in = sat_sample(mix3 >>> Q_FRAC);

   always_ff @(posedge clock) begin
      if (v3_ff && adv) begin
         out_ff <= out_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage valids and output valid
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            v1_ff <= accept;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
         if (v3_ff && adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.audio_out = out_ff;

endmodule

@@ hw/rtl/bfe_checker.sv @@
// ============================================================================
// bfe_checker
// Port-level checks for the bitcrushed feedback echo, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps

module bfe_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bfe_pkg::sample_type audio_out
);
   import bfe_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a waiting result keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(audio_out))
      else $error("rsp payload changed while stalled");

   // input only backs up when a result is stuck at the output
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req not ready without output stall");

   // with a sink that stays ready after acceptance, the result must be offered
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_fire ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready) |=> rsp_valid)
      else $error("result missing after pipeline latency");

   // nothing offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind bitcrushed_feedback_echo_core bfe_checker u_bfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .audio_out (rsp_chan.audio_out)
);
